/* design/i2c_master_transfer_sequencer_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH

// Property checked on every rising edge, idle while reset is high.
`define I2CMTS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define I2CMTS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* design/i2cmts_pkg.sv */
package i2cmts_pkg;

  // default buffer depths
  localparam int SEND_DEPTH_DEF = 16;
  localparam int RECV_DEPTH_DEF = 16;

  // item kinds
  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_START = 3'd1,
    MODE_EVENT = 3'd2,
    MODE_ERROR = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  // bus events
  typedef enum logic [1:0] {
    EV_START_SENT = 2'd0,
    EV_ADDR_SENT  = 2'd1,
    EV_TX_EMPTY   = 2'd2,
    EV_BYTE_RCVD  = 2'd3
  } ev_t;

  // bus actions
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_ADDR_W = 3'd2,
    ACT_ADDR_R = 3'd3,
    ACT_BYTE   = 3'd4,
    ACT_STOP   = 3'd5
  } act_t;

  // acknowledge control
  typedef enum logic [1:0] {
    ACK_KEEP = 2'd0,
    ACK_OFF  = 2'd1,
    ACK_ON   = 2'd2
  } ack_t;

  // start command reply
  typedef enum logic [1:0] {
    CMD_OK   = 2'd0,
    CMD_BUSY = 2'd1,
    CMD_ARG  = 2'd2
  } cmd_t;

  // transfer result
  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_UNKNOWN = 3'd1,
    RES_NACK    = 3'd2,
    RES_OVR     = 3'd3,
    RES_ARB     = 3'd4,
    RES_BUS     = 3'd5
  } res_t;

  // address direction bit
  localparam logic [7:0] DIR_READ = 8'h01;

  // result of one beat before the buffer read data is merged in
  typedef struct packed {
    act_t       act;
    logic [7:0] obyte;
    logic       from_send;  // out_byte comes from the send buffer
    ack_t       ack;
    logic       clr;
    logic       irq;
    cmd_t       cmd;
    logic       busy;
    res_t       res;
    logic       rd_sel;     // read_data comes from the receive buffer
  } step_t;

endpackage

/* design/i2cmts_core.sv */
module i2cmts_core #(
  parameter int SEND_DEPTH = i2cmts_pkg::SEND_DEPTH_DEF,
  parameter int RECV_DEPTH = i2cmts_pkg::RECV_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [2:0]         mode,
  input  logic [3:0]         buf_index,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         slave_address,
  input  logic [7:0]         write_count,
  input  logic [7:0]         read_count,
  input  logic [1:0]         event_kind,
  input  logic [3:0]         error_flags,
  input  logic               bus_busy,
  output i2cmts_pkg::step_t  s1,
  output logic [7:0]         send_q,
  output logic [7:0]         recv_q
);

  localparam int SCW = $clog2(SEND_DEPTH + 1);
  localparam int RCW = $clog2(RECV_DEPTH + 1);
  localparam int SAW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam int RAW = (RECV_DEPTH > 1) ? $clog2(RECV_DEPTH) : 1;
  localparam logic [7:0] SEND_LIM = 8'(SEND_DEPTH);
  localparam logic [7:0] RECV_LIM = 8'(RECV_DEPTH);

  // control state
  logic                 active, active_next;
  logic                 receiving, receiving_next;
  logic [7:0]           target_address, target_address_next;
  logic [SCW-1:0]       send_total, send_total_next;
  logic [RCW-1:0]       recv_total, recv_total_next;
  logic [SCW-1:0]       sent_so_far, sent_so_far_next;
  logic [RCW-1:0]       recv_so_far, recv_so_far_next;
  i2cmts_pkg::res_t     last_result, last_result_next;
  logic                 irq_on, irq_on_next;

  // buffers
  logic [7:0] send_mem [SEND_DEPTH];
  logic [7:0] recv_mem [RECV_DEPTH];

  i2cmts_pkg::step_t    step;
  i2cmts_pkg::res_t     err_res;
  logic                 send_we, recv_we;
  logic [SAW+3:0]       load_ext;
  logic [RAW+3:0]       rback_ext;
  logic [SAW-1:0]       load_addr;
  logic [RAW-1:0]       rback_addr;
  logic [RCW-1:0]       recv_inc;
  logic [RCW-1:0]       recv_left;

  assign load_ext   = {{SAW{1'b0}}, buf_index};
  assign rback_ext  = {{RAW{1'b0}}, buf_index};
  assign load_addr  = load_ext[SAW-1:0];
  assign rback_addr = rback_ext[RAW-1:0];
  assign recv_inc   = recv_so_far + 1'b1;
  assign recv_left  = recv_total - recv_so_far;

  // error priority: bus error > lost arbitration > overrun > no ack
  always_comb begin
    if (error_flags[3]) begin
      err_res = i2cmts_pkg::RES_BUS;
    end else if (error_flags[2]) begin
      err_res = i2cmts_pkg::RES_ARB;
    end else if (error_flags[1]) begin
      err_res = i2cmts_pkg::RES_OVR;
    end else if (error_flags[0]) begin
      err_res = i2cmts_pkg::RES_NACK;
    end else begin
      err_res = last_result;
    end
  end

  // next state and beat result
  always_comb begin
    active_next         = active;
    receiving_next      = receiving;
    target_address_next = target_address;
    send_total_next     = send_total;
    recv_total_next     = recv_total;
    sent_so_far_next    = sent_so_far;
    recv_so_far_next    = recv_so_far;
    last_result_next    = last_result;
    irq_on_next         = irq_on;
    send_we             = 1'b0;
    recv_we             = 1'b0;
    step.act            = i2cmts_pkg::ACT_NONE;
    step.obyte          = 8'h00;
    step.from_send      = 1'b0;
    step.ack            = i2cmts_pkg::ACK_KEEP;
    step.clr            = 1'b0;
    step.cmd            = i2cmts_pkg::CMD_OK;
    step.rd_sel         = 1'b0;

    unique case (mode)
      i2cmts_pkg::MODE_LOAD: begin
        send_we = !active && ({4'h0, buf_index} < SEND_LIM);
      end
      i2cmts_pkg::MODE_START: begin
        if (read_count > RECV_LIM || write_count > SEND_LIM) begin
          step.cmd = i2cmts_pkg::CMD_ARG;
        end else if (active || bus_busy) begin
          step.cmd = i2cmts_pkg::CMD_BUSY;
        end else begin
          active_next      = 1'b1;
          last_result_next = i2cmts_pkg::RES_UNKNOWN;
          send_total_next  = SCW'(write_count);
          recv_total_next  = RCW'(read_count);
          sent_so_far_next = '0;
          recv_so_far_next = '0;
          if (write_count != 8'h00) begin
            receiving_next      = 1'b0;
            target_address_next = slave_address & ~i2cmts_pkg::DIR_READ;
          end else if (read_count != 8'h00) begin
            receiving_next      = 1'b1;
            target_address_next = slave_address | i2cmts_pkg::DIR_READ;
          end
          irq_on_next = 1'b1;
          step.act    = i2cmts_pkg::ACT_START;
        end
      end
      i2cmts_pkg::MODE_EVENT: begin
        if (irq_on && !receiving) begin
          // write phase
          unique case (event_kind)
            i2cmts_pkg::EV_START_SENT: begin
              step.act   = i2cmts_pkg::ACT_ADDR_W;
              step.obyte = target_address & ~i2cmts_pkg::DIR_READ;
            end
            i2cmts_pkg::EV_ADDR_SENT: begin
              step.clr = 1'b1;
            end
            i2cmts_pkg::EV_TX_EMPTY: begin
              if (sent_so_far < send_total) begin
                step.act         = i2cmts_pkg::ACT_BYTE;
                step.from_send   = 1'b1;
                sent_so_far_next = sent_so_far + 1'b1;
              end else if (recv_so_far < recv_total) begin
                receiving_next = 1'b1;
                step.act       = i2cmts_pkg::ACT_START;
              end else begin
                step.act         = i2cmts_pkg::ACT_STOP;
                irq_on_next      = 1'b0;
                active_next      = 1'b0;
                last_result_next = i2cmts_pkg::RES_OK;
              end
            end
            default: ;
          endcase
        end else if (irq_on) begin
          // read phase
          unique case (event_kind)
            i2cmts_pkg::EV_START_SENT: begin
              step.act   = i2cmts_pkg::ACT_ADDR_R;
              step.obyte = target_address | i2cmts_pkg::DIR_READ;
            end
            i2cmts_pkg::EV_ADDR_SENT: begin
              step.ack = (8'(recv_total) < 8'd2) ? i2cmts_pkg::ACK_OFF : i2cmts_pkg::ACK_ON;
              step.clr = 1'b1;
            end
            i2cmts_pkg::EV_BYTE_RCVD: begin
              // ack off ahead of the last two bytes
              step.ack = (8'(recv_left) < 8'd3) ? i2cmts_pkg::ACK_OFF : i2cmts_pkg::ACK_ON;
              if (recv_so_far < recv_total) begin
                recv_we          = 1'b1;
                recv_so_far_next = recv_inc;
                if (recv_inc == recv_total) begin
                  step.act         = i2cmts_pkg::ACT_STOP;
                  irq_on_next      = 1'b0;
                  active_next      = 1'b0;
                  last_result_next = i2cmts_pkg::RES_OK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      i2cmts_pkg::MODE_ERROR: begin
        if (irq_on) begin
          step.act         = i2cmts_pkg::ACT_STOP;
          irq_on_next      = 1'b0;
          active_next      = 1'b0;
          last_result_next = err_res;
        end
      end
      i2cmts_pkg::MODE_READ: begin
        step.rd_sel = {4'h0, buf_index} < RECV_LIM;
      end
      default: ;
    endcase

    step.irq  = irq_on_next;
    step.busy = active_next || bus_busy;
    step.res  = last_result_next;
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      receiving      <= 1'b1;
      target_address <= 8'h00;
      send_total     <= '0;
      recv_total     <= '0;
      sent_so_far    <= '0;
      recv_so_far    <= '0;
      last_result    <= i2cmts_pkg::RES_OK;
      irq_on         <= 1'b0;
    end else if (take) begin
      active         <= active_next;
      receiving      <= receiving_next;
      target_address <= target_address_next;
      send_total     <= send_total_next;
      recv_total     <= recv_total_next;
      sent_so_far    <= sent_so_far_next;
      recv_so_far    <= recv_so_far_next;
      last_result    <= last_result_next;
      irq_on         <= irq_on_next;
    end
  end

  // beat result register
  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= step;
    end
  end

  // send buffer: load port, read at the next byte to send
  always_ff @(posedge clk) begin
    if (take && send_we) begin
      send_mem[load_addr] <= data_byte;
    end
    if (take) begin
      send_q <= send_mem[sent_so_far[SAW-1:0]];
    end
  end

  // receive buffer: store received byte, read back at buf_index
  always_ff @(posedge clk) begin
    if (take && recv_we) begin
      recv_mem[recv_so_far[RAW-1:0]] <= data_byte;
    end
    if (take) begin
      recv_q <= recv_mem[rback_addr];
    end
  end

endmodule

/* design/i2c_master_transfer_sequencer_top.sv */
// I2C master transfer sequencer. Takes one beat per cycle on the input channel
// unless the output stalls, and returns exactly one result beat for each, in
// order, through the beat result register and then the output register. All state
// (counters, flags, the send and receive buffers) is updated in a single pass at the
// accepting edge; the buffer read data is registered there and merged into the output
// register when the beat advances, so a new beat can enter every cycle while the
// output is ready. Up to two results are held internally, so input keeps flowing for
// one beat while the output stalls. Loads are ignored while a transfer runs, and a
// readback of a receive slot never written returns an undefined byte.
module i2c_master_transfer_sequencer_top #(
  parameter int SEND_DEPTH = i2cmts_pkg::SEND_DEPTH_DEF,
  parameter int RECV_DEPTH = i2cmts_pkg::RECV_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] mode,
  input  logic [3:0] buf_index,
  input  logic [7:0] data_byte,
  input  logic [7:0] slave_address,
  input  logic [7:0] write_count,
  input  logic [7:0] read_count,
  input  logic [1:0] event_kind,
  input  logic [3:0] error_flags,
  input  logic       bus_busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] bus_action,
  output logic [7:0] out_byte,
  output logic [1:0] ack_setting,
  output logic       clear_address_flag,
  output logic       events_enabled,
  output logic [1:0] command_code,
  output logic       busy_res,
  output logic [2:0] result_code,
  output logic [7:0] read_data
);

  i2cmts_pkg::step_t s1;
  logic [7:0]        send_q, recv_q;
  logic              v1;
  logic              adv1, take;

  // pipeline flow
  assign adv1     = v1 && (!out_valid || out_ready);
  assign in_ready = !v1 || adv1;
  assign take     = in_valid && in_ready;

  i2cmts_core #(
    .SEND_DEPTH (SEND_DEPTH),
    .RECV_DEPTH (RECV_DEPTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .mode          (mode),
    .buf_index     (buf_index),
    .data_byte     (data_byte),
    .slave_address (slave_address),
    .write_count   (write_count),
    .read_count    (read_count),
    .event_kind    (event_kind),
    .error_flags   (error_flags),
    .bus_busy      (bus_busy),
    .s1            (s1),
    .send_q        (send_q),
    .recv_q        (recv_q)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register, buffer data merged in
  always_ff @(posedge clk) begin
    if (adv1) begin
      bus_action         <= s1.act;
      out_byte           <= s1.from_send ? send_q : s1.obyte;
      ack_setting        <= s1.ack;
      clear_address_flag <= s1.clr;
      events_enabled     <= s1.irq;
      command_code       <= s1.cmd;
      busy_res           <= s1.busy;
      result_code        <= s1.res;
      read_data          <= s1.rd_sel ? recv_q : 8'h00;
    end
  end

endmodule

/* design/i2cmts_checker.sv */
`include "i2c_master_transfer_sequencer_top_macros.svh"

module i2cmts_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] bus_action,
  input logic [1:0] command_code,
  input logic       events_enabled,
  input logic       busy_res,
  input logic [7:0] read_data
);

  // a stalled result beat holds
  `I2CMTS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(bus_action) && $stable(read_data), "result beat changed while stalled")

  // no result right after reset
  `I2CMTS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "result valid after reset")

  // a stop ends the transfer and masks events
  `I2CMTS_ASSERT(a_stop_masks, clk, rst, out_valid && bus_action == i2cmts_pkg::ACT_STOP |-> !events_enabled, "events still enabled after stop")

  // events only enabled while a transfer runs
  `I2CMTS_ASSERT(a_irq_busy, clk, rst, out_valid && events_enabled |-> busy_res, "events enabled while not busy")

  // a refused start drives nothing on the bus
  `I2CMTS_ASSERT(a_refused_idle, clk, rst, out_valid && command_code != i2cmts_pkg::CMD_OK |-> bus_action == i2cmts_pkg::ACT_NONE, "bus action on refused start")

endmodule

bind i2c_master_transfer_sequencer_top i2cmts_checker u_i2cmts_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .bus_action     (bus_action),
  .command_code   (command_code),
  .events_enabled (events_enabled),
  .busy_res       (busy_res),
  .read_data      (read_data)
);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS       = 800;
  localparam int LONG_STALL  = 120;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_REPORTS = 10;

  // one input beat as the driver presents it
  typedef struct {
    logic [2:0]        mode;
    logic [3:0]        slot;
    logic [7:0]        data;
    logic [7:0]        addr;
    logic [7:0]        wr_cnt;
    logic [7:0]        rd_cnt;
    i2cmts_pkg::ev_t   ev;
    logic [3:0]        flags;
    logic              busy;
    bit                drain_first;  // hold this beat until all results are back
  } beat_t;

  // one result beat
  typedef struct packed {
    i2cmts_pkg::act_t  act;
    logic [7:0]        obyte;
    i2cmts_pkg::ack_t  ack;
    logic              clr;
    logic              irq;
    i2cmts_pkg::cmd_t  cmd;
    logic              busy;
    i2cmts_pkg::res_t  res;
    logic [7:0]        rdata;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] mode = '0;
  logic [3:0] buf_index = '0;
  logic [7:0] data_byte = '0;
  logic [7:0] slave_address = '0;
  logic [7:0] write_count = '0;
  logic [7:0] read_count = '0;
  logic [1:0] event_kind = '0;
  logic [3:0] error_flags = '0;
  logic       bus_busy = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] bus_action;
  logic [7:0] out_byte;
  logic [1:0] ack_setting;
  logic       clear_address_flag;
  logic       events_enabled;
  logic [1:0] command_code;
  logic       busy_res;
  logic [2:0] result_code;
  logic [7:0] read_data;

  i2c_master_transfer_sequencer_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  beat_t    beats_to_send[$];
  outcome_t due_results[$];
  beat_t    cur;
  int       n_total = 0;
  int       n_acc = 0;
  int       n_out = 0;
  int       n_err = 0;
  int       stall_left = 0;
  int       stalls_done = 0;

  // shadow of the sequencer state
  logic             xfer_active = 1'b0;
  logic             rx_phase = 1'b1;
  logic [7:0]       target = '0;
  logic [4:0]       send_total = '0;
  logic [4:0]       recv_total = '0;
  logic [4:0]       sent_cnt = '0;
  logic [4:0]       recv_cnt = '0;
  i2cmts_pkg::res_t last_res = i2cmts_pkg::RES_OK;
  logic             irq_on = 1'b0;
  logic [7:0]       send_mem [i2cmts_pkg::SEND_DEPTH_DEF];
  logic [7:0]       recv_mem [i2cmts_pkg::RECV_DEPTH_DEF];

  // stop the bus and close the transfer
  task automatic end_transfer(inout outcome_t r, input i2cmts_pkg::res_t code);
    r.act = i2cmts_pkg::ACT_STOP;
    irq_on = 1'b0;
    xfer_active = 1'b0;
    last_res = code;
  endtask

  // advance the shadow state by one beat and queue the result it must give
  task automatic sequence_beat(input beat_t b);
    outcome_t         r;
    i2cmts_pkg::res_t pick;
    int               left;
    r = '0;
    case (b.mode)
      i2cmts_pkg::MODE_LOAD: begin
        if (!xfer_active && b.slot < i2cmts_pkg::SEND_DEPTH_DEF) send_mem[b.slot] = b.data;
      end
      i2cmts_pkg::MODE_START: begin
        if (b.rd_cnt > i2cmts_pkg::RECV_DEPTH_DEF || b.wr_cnt > i2cmts_pkg::SEND_DEPTH_DEF) begin
          r.cmd = i2cmts_pkg::CMD_ARG;
        end else if (xfer_active || b.busy) begin
          r.cmd = i2cmts_pkg::CMD_BUSY;
        end else begin
          xfer_active = 1'b1;
          last_res = i2cmts_pkg::RES_UNKNOWN;
          send_total = b.wr_cnt[4:0];
          recv_total = b.rd_cnt[4:0];
          sent_cnt = '0;
          recv_cnt = '0;
          // empty transfer keeps direction and address
          if (b.wr_cnt != 0) begin
            rx_phase = 1'b0;
            target = b.addr & ~i2cmts_pkg::DIR_READ;
          end else if (b.rd_cnt != 0) begin
            rx_phase = 1'b1;
            target = b.addr | i2cmts_pkg::DIR_READ;
          end
          irq_on = 1'b1;
          r.act = i2cmts_pkg::ACT_START;
        end
      end
      i2cmts_pkg::MODE_EVENT: begin
        if (irq_on && !rx_phase) begin
          case (b.ev)
            i2cmts_pkg::EV_START_SENT: begin
              r.act = i2cmts_pkg::ACT_ADDR_W;
              r.obyte = target & ~i2cmts_pkg::DIR_READ;
            end
            i2cmts_pkg::EV_ADDR_SENT: r.clr = 1'b1;
            i2cmts_pkg::EV_TX_EMPTY: begin
              if (sent_cnt < send_total) begin
                r.act = i2cmts_pkg::ACT_BYTE;
                r.obyte = send_mem[sent_cnt];
                sent_cnt++;
              end else if (recv_cnt < recv_total) begin
                // repeated start into the read phase
                rx_phase = 1'b1;
                r.act = i2cmts_pkg::ACT_START;
              end else begin
                end_transfer(r, i2cmts_pkg::RES_OK);
              end
            end
            default: ;
          endcase
        end else if (irq_on) begin
          case (b.ev)
            i2cmts_pkg::EV_START_SENT: begin
              r.act = i2cmts_pkg::ACT_ADDR_R;
              r.obyte = target | i2cmts_pkg::DIR_READ;
            end
            i2cmts_pkg::EV_ADDR_SENT: begin
              r.ack = (recv_total < 2) ? i2cmts_pkg::ACK_OFF : i2cmts_pkg::ACK_ON;
              r.clr = 1'b1;
            end
            i2cmts_pkg::EV_BYTE_RCVD: begin
              // NACK goes out ahead of the last two bytes
              left = int'(recv_total) - int'(recv_cnt);
              r.ack = (left < 3) ? i2cmts_pkg::ACK_OFF : i2cmts_pkg::ACK_ON;
              if (recv_cnt < recv_total) begin
                recv_mem[recv_cnt] = b.data;
                recv_cnt++;
                if (recv_cnt == recv_total) end_transfer(r, i2cmts_pkg::RES_OK);
              end
            end
            default: ;
          endcase
        end
      end
      i2cmts_pkg::MODE_ERROR: begin
        if (irq_on) begin
          // later checks override earlier ones
          pick = last_res;
          if (b.flags[0]) pick = i2cmts_pkg::RES_NACK;
          if (b.flags[1]) pick = i2cmts_pkg::RES_OVR;
          if (b.flags[2]) pick = i2cmts_pkg::RES_ARB;
          if (b.flags[3]) pick = i2cmts_pkg::RES_BUS;
          end_transfer(r, pick);
        end
      end
      i2cmts_pkg::MODE_READ: begin
        if (b.slot < i2cmts_pkg::RECV_DEPTH_DEF) r.rdata = recv_mem[b.slot];
      end
      default: ;
    endcase
    r.irq = irq_on;
    r.busy = xfer_active | b.busy;
    r.res = last_res;
    due_results.push_back(r);
  endtask

  function automatic int idle_pct(bit rx_side);
    int ph;
    ph = n_acc * 3 / n_total;
    if (ph == 0) return rx_side ? 56 : 30;
    if (ph == 1) return rx_side ? 30 : 56;
    return 0;
  endfunction

  // fully random beat; callers override what matters
  function automatic beat_t any_beat();
    beat_t b;
    b.mode = 3'($urandom);
    b.slot = 4'($urandom);
    b.data = 8'($urandom);
    b.addr = 8'($urandom);
    b.wr_cnt = 8'($urandom);
    b.rd_cnt = 8'($urandom);
    b.ev = i2cmts_pkg::ev_t'($urandom_range(3));
    b.flags = 4'($urandom);
    b.busy = 1'($urandom_range(1));
    b.drain_first = 1'b0;
    return b;
  endfunction

  task automatic push_load(input logic [3:0] idx, input logic [7:0] val);
    beat_t b;
    b = any_beat();
    b.mode = i2cmts_pkg::MODE_LOAD;
    b.slot = idx;
    b.data = val;
    beats_to_send.push_back(b);
  endtask

  task automatic push_start(input int w, input int rd, input logic [7:0] addr,
                            input bit busy);
    beat_t b;
    b = any_beat();
    b.mode = i2cmts_pkg::MODE_START;
    b.wr_cnt = 8'(w);
    b.rd_cnt = 8'(rd);
    b.addr = addr;
    b.busy = busy;
    beats_to_send.push_back(b);
  endtask

  task automatic push_event(input i2cmts_pkg::ev_t k);
    beat_t b;
    b = any_beat();
    b.mode = i2cmts_pkg::MODE_EVENT;
    b.ev = k;
    beats_to_send.push_back(b);
  endtask

  task automatic push_error(input logic [3:0] flags);
    beat_t b;
    b = any_beat();
    b.mode = i2cmts_pkg::MODE_ERROR;
    b.flags = flags;
    beats_to_send.push_back(b);
  endtask

  task automatic push_read(input logic [3:0] idx);
    beat_t b;
    b = any_beat();
    b.mode = i2cmts_pkg::MODE_READ;
    b.slot = idx;
    beats_to_send.push_back(b);
  endtask

  // mostly short counts, some full-depth, some zero
  function automatic int pick_count(int depth);
    int r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 23) return depth;
    return $urandom_range(6, 1);
  endfunction

  // well-formed transfer with random content, now and then cut short or disturbed
  task automatic push_transfer();
    i2cmts_pkg::ev_t plan[$];
    int              w, rd, cut;
    bit              noisy;
    noisy = 1'b0;
    w = pick_count(i2cmts_pkg::SEND_DEPTH_DEF);
    rd = pick_count(i2cmts_pkg::RECV_DEPTH_DEF);
    repeat ($urandom_range(3)) push_load(4'($urandom), 8'($urandom));
    push_start(w, rd, 8'($urandom), $urandom_range(9) == 0);
    if (w > 0) begin
      plan.push_back(i2cmts_pkg::EV_START_SENT);
      plan.push_back(i2cmts_pkg::EV_ADDR_SENT);
      repeat (w + 1) plan.push_back(i2cmts_pkg::EV_TX_EMPTY);
    end
    if (rd > 0) begin
      plan.push_back(i2cmts_pkg::EV_START_SENT);
      plan.push_back(i2cmts_pkg::EV_ADDR_SENT);
      repeat (rd) plan.push_back(i2cmts_pkg::EV_BYTE_RCVD);
    end
    if (w == 0 && rd == 0) plan.push_back(i2cmts_pkg::EV_TX_EMPTY);
    cut = ($urandom_range(7) == 0) ? $urandom_range(plan.size() - 1) : plan.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(15) == 0) begin
        beats_to_send.push_back(any_beat());
        noisy = 1'b1;
      end
      push_event(plan[i]);
    end
    // make sure nothing is left hanging
    if (cut < plan.size() || noisy || (w == 0 && rd == 0)) push_error(4'($urandom));
    repeat ($urandom_range(2)) push_read(4'($urandom));
  endtask

  // input driver
  always @(posedge clk) begin : drive_beats
    bit took;
    took = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        sequence_beat(cur);
        n_acc <= n_acc + 1;
      end
      if (!in_valid || took) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= idle_pct(1'b0) &&
            !(beats_to_send[0].drain_first && (took || n_acc != n_out))) begin
          cur = beats_to_send.pop_front();
          mode <= cur.mode;
          buf_index <= cur.slot;
          data_byte <= cur.data;
          slave_address <= cur.addr;
          write_count <= cur.wr_cnt;
          read_count <= cur.rd_cnt;
          event_kind <= cur.ev;
          error_flags <= cur.flags;
          bus_busy <= cur.busy;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output ready, with two long hold-offs
  always @(posedge clk) begin : pace_receiver
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      stalls_done <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stalls_done < 2 &&
                 n_acc >= ((stalls_done == 0) ? n_total / 5 : n_total * 4 / 5)) begin
      stall_left <= LONG_STALL;
      stalls_done <= stalls_done + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  task automatic note_error(input string msg);
    n_err++;
    if (n_err <= MAX_REPORTS) $display("ERROR result %0d:%s", n_out, msg);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    outcome_t got, want;
    string    msg;
    if (!rst && out_valid && out_ready) begin
      n_out <= n_out + 1;
      got.act = i2cmts_pkg::act_t'(bus_action);
      got.obyte = out_byte;
      got.ack = i2cmts_pkg::ack_t'(ack_setting);
      got.clr = clear_address_flag;
      got.irq = events_enabled;
      got.cmd = i2cmts_pkg::cmd_t'(command_code);
      got.busy = busy_res;
      got.res = i2cmts_pkg::res_t'(result_code);
      got.rdata = read_data;
      if (due_results.size() == 0) begin
        note_error(" result beat with nothing expected");
      end else begin
        want = due_results.pop_front();
        msg = "";
        if (got.act !== want.act)
          msg = {msg, $sformatf(" bus_action exp %0d got %0d", want.act, got.act)};
        if (got.obyte !== want.obyte)
          msg = {msg, $sformatf(" out_byte exp %h got %h", want.obyte, got.obyte)};
        if (got.ack !== want.ack)
          msg = {msg, $sformatf(" ack_setting exp %0d got %0d", want.ack, got.ack)};
        if (got.clr !== want.clr)
          msg = {msg, $sformatf(" clear_address_flag exp %b got %b", want.clr, got.clr)};
        if (got.irq !== want.irq)
          msg = {msg, $sformatf(" events_enabled exp %b got %b", want.irq, got.irq)};
        if (got.cmd !== want.cmd)
          msg = {msg, $sformatf(" command_code exp %0d got %0d", want.cmd, got.cmd)};
        if (got.busy !== want.busy)
          msg = {msg, $sformatf(" busy_res exp %b got %b", want.busy, got.busy)};
        if (got.res !== want.res)
          msg = {msg, $sformatf(" result_code exp %0d got %0d", want.res, got.res)};
        if (got.rdata !== want.rdata)
          msg = {msg, $sformatf(" read_data exp %h got %h", want.rdata, got.rdata)};
        if (msg != "") note_error(msg);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int first_rand;

    // fill both buffers so no slot is ever read before it is written
    for (int i = 0; i < i2cmts_pkg::SEND_DEPTH_DEF; i++) push_load(4'(i), 8'($urandom));
    push_start(0, i2cmts_pkg::RECV_DEPTH_DEF, 8'($urandom), 1'b0);
    push_event(i2cmts_pkg::EV_START_SENT);
    push_event(i2cmts_pkg::EV_ADDR_SENT);
    repeat (i2cmts_pkg::RECV_DEPTH_DEF) push_event(i2cmts_pkg::EV_BYTE_RCVD);

    // directed: readback extremes, ignored events, unknown modes
    push_read(4'd0);
    push_read(4'(i2cmts_pkg::RECV_DEPTH_DEF - 1));
    push_event(i2cmts_pkg::EV_BYTE_RCVD);
    push_error(4'hF);
    for (int m = int'(i2cmts_pkg::MODE_READ) + 1; m < 2 ** $bits(i2cmts_pkg::mode_t); m++) begin
      beats_to_send.push_back(any_beat());
      beats_to_send[$].mode = 3'(m);
    end
    // argument errors win over busy
    push_start(i2cmts_pkg::SEND_DEPTH_DEF + 1, 0, 8'($urandom), 1'b0);
    push_start(0, 255, 8'($urandom), 1'b0);
    push_start(255, 255, 8'($urandom), 1'b1);
    push_start(2, 2, 8'($urandom), 1'b1);
    // empty transfer, start while active, error with no flag
    push_start(0, 0, 8'($urandom), 1'b0);
    push_start(1, 1, 8'($urandom), 1'b0);
    push_event(i2cmts_pkg::EV_TX_EMPTY);
    push_error(4'b0000);
    // write one byte, repeated start, read two; stray events on the way
    push_start(1, 2, 8'hFF, 1'b0);
    push_load(4'd0, 8'hAA);
    push_event(i2cmts_pkg::EV_START_SENT);
    push_event(i2cmts_pkg::EV_ADDR_SENT);
    push_event(i2cmts_pkg::EV_BYTE_RCVD);
    push_event(i2cmts_pkg::EV_TX_EMPTY);
    push_event(i2cmts_pkg::EV_TX_EMPTY);
    push_event(i2cmts_pkg::EV_TX_EMPTY);
    push_event(i2cmts_pkg::EV_START_SENT);
    push_event(i2cmts_pkg::EV_ADDR_SENT);
    push_event(i2cmts_pkg::EV_BYTE_RCVD);
    push_event(i2cmts_pkg::EV_BYTE_RCVD);
    // full write depth aborted by two flags; single read aborted by two flags
    push_start(i2cmts_pkg::SEND_DEPTH_DEF, 0, 8'h00, 1'b0);
    push_error(4'b0011);
    push_start(0, 1, 8'($urandom), 1'b0);
    push_event(i2cmts_pkg::EV_START_SENT);
    push_event(i2cmts_pkg::EV_ADDR_SENT);
    push_error(4'b0101);

    // random part
    first_rand = beats_to_send.size();
    while (beats_to_send.size() < ITEMS) begin
      if ($urandom_range(3) != 0) push_transfer();
      else beats_to_send.push_back(any_beat());
    end
    n_total = beats_to_send.size();
    beats_to_send[first_rand].drain_first = 1'b1;
    beats_to_send[n_total / 2].drain_first = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (n_acc < n_total || n_out < n_total) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (n_err == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
